FILE: sv/spc_pkg.sv
// signal pending controller package: word types, code constants and helper functions
// shared by every module of the block but spc_pick; no dependencies
`default_nettype none

package spc_pkg;

    localparam int unsigned SigMaxDefault = 63;
    localparam int unsigned SigWidth      = 64;
    localparam int unsigned SigNumWidth   = 6;
    localparam int unsigned CfgIdxWidth   = 2;

    // signal numbers
    localparam logic [5:0] SQuit = 6'd3;
    localparam logic [5:0] SIll  = 6'd4;
    localparam logic [5:0] STrap = 6'd5;
    localparam logic [5:0] SAbrt = 6'd6;
    localparam logic [5:0] SBus  = 6'd7;
    localparam logic [5:0] SFpe  = 6'd8;
    localparam logic [5:0] SKill = 6'd9;
    localparam logic [5:0] SSegv = 6'd11;
    localparam logic [5:0] SChld = 6'd17;
    localparam logic [5:0] SCont = 6'd18;
    localparam logic [5:0] SStop = 6'd19;
    localparam logic [5:0] STstp = 6'd20;
    localparam logic [5:0] STtin = 6'd21;
    localparam logic [5:0] STtou = 6'd22;

    localparam logic [63:0] UncatchSet = (64'd1 << SKill) | (64'd1 << SStop);
    localparam logic [63:0] StopSet    = (64'd1 << SStop) | (64'd1 << STstp) |
                                         (64'd1 << STtin) | (64'd1 << STtou);

    // configuration register indexes
    localparam logic [1:0] CfgBlocked = 2'd0;
    localparam logic [1:0] CfgIgnore  = 2'd1;
    localparam logic [1:0] CfgCustom  = 2'd2;

    // function codes
    localparam logic FuncSend = 1'b0;
    localparam logic FuncPick = 1'b1;

    // status codes
    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatInvalid = 2'd1;
    localparam logic [1:0] StatNoTask  = 2'd2;

    // action codes
    localparam logic [2:0] ActNone   = 3'd0;
    localparam logic [2:0] ActTerm   = 3'd1;
    localparam logic [2:0] ActCore   = 3'd2;
    localparam logic [2:0] ActDIgn   = 3'd3;
    localparam logic [2:0] ActStop   = 3'd4;
    localparam logic [2:0] ActCont   = 3'd5;
    localparam logic [2:0] ActCustom = 3'd6;
    localparam logic [2:0] ActHIgn   = 3'd7;

    typedef enum logic [1:0] {
        RUN_READY   = 2'd0,
        RUN_STOPPED = 2'd1,
        RUN_DEAD    = 2'd2
    } t_run_state;

    typedef struct packed {
        logic       func;
        logic [5:0] signal_number;
        logic       custom_ok;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] picked_signal;
        logic [2:0] action_taken;
        logic [1:0] run_state_out;
        logic       resumed;
    } t_out_word;

    typedef struct packed {
        logic [63:0] blocked;
        logic [63:0] ignore;
        logic [63:0] custom;
    } t_cfg;

    // bit n set for every signal number 1..max
    function automatic logic [63:0] valid_mask(int unsigned max);
        logic [63:0] m;
        m = '0;
        for (int n = 1; n < 64; n++) begin
            if (n <= max) begin
                m[n] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [2:0] default_action(logic [5:0] n);
        logic [2:0] act;
        unique case (n) inside
            SQuit, SIll, STrap, SAbrt, SBus, SFpe, SSegv: act = ActCore;
            SChld:                                        act = ActDIgn;
            SCont:                                        act = ActCont;
            SStop, STstp, STtin, STtou:                   act = ActStop;
            default:                                      act = ActTerm;
        endcase
        return act;
    endfunction

endpackage

`default_nettype wire

FILE: sv/signal_pending_controller.sv
// path: an accepted input word goes through the input register, then the result register;
// throughput: one word per cycle when the output does not stall, set by the single-pass
// priority encoder and state update between the two registers
// reset: pending set cleared, task ready, all three masks zero, both stages empty
// top level of the signal pending controller; uses spc_pkg, spc_cfg_regs, spc_step
`default_nettype none

module signal_pending_controller #(
    parameter int unsigned SIGNAL_MAX = spc_pkg::SigMaxDefault
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  spc_pkg::t_in_word        i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output spc_pkg::t_out_word       o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [63:0]         i_cfg_data
);

    spc_pkg::t_cfg       cfg;
    logic                r_in_valid;
    spc_pkg::t_in_word   r_in_word;
    logic                r_out_valid;
    spc_pkg::t_out_word  r_out_word;
    logic [63:0]         r_pending;
    spc_pkg::t_run_state r_run_state;
    logic [63:0]         n_pending;
    spc_pkg::t_run_state n_run_state;
    spc_pkg::t_out_word  n_out_word;
    logic                out_free;
    logic                advance;
    logic                in_take;

    spc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    spc_step #(
        .SIGNAL_MAX (SIGNAL_MAX)
    ) u_step (
        .i_word          (r_in_word),
        .i_pending       (r_pending),
        .i_run_state     (r_run_state),
        .i_cfg           (cfg),
        .o_pending_nxt   (n_pending),
        .o_run_state_nxt (n_run_state),
        .o_result        (n_out_word)
    );

    // state commits only when the word moves into the result register
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_run_state <= spc_pkg::RUN_READY;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_pending   <= n_pending;
                r_run_state <= n_run_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_data;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire

FILE: sv/spc_cfg_regs.sv
// configuration registers: blocked, ignore and custom handler masks
// uses spc_pkg for the index codes and the mask struct
`default_nettype none

module spc_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [63:0]         i_cfg_data,
    output spc_pkg::t_cfg            o_cfg
);

    spc_pkg::t_cfg r_cfg;
    spc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spc_pkg::CfgBlocked: n_cfg.blocked = i_cfg_data;
                spc_pkg::CfgIgnore:  n_cfg.ignore  = i_cfg_data;
                spc_pkg::CfgCustom:  n_cfg.custom  = i_cfg_data;
                default:             n_cfg         = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/spc_pick.sv
// lowest-set-bit priority encoder over the candidate signal set
// no package dependencies
`default_nettype none

module spc_pick (
    input  wire logic [63:0] i_cand,
    output logic             o_found,
    output logic [5:0]       o_index
);

    logic [63:0] lowest;

    // isolate the lowest set bit, then encode the one-hot word
    always_comb begin
        lowest  = i_cand & (~i_cand + 64'd1);
        o_found = |i_cand;
        o_index = '0;
        for (int i = 0; i < 64; i++) begin
            if (lowest[i]) begin
                o_index = o_index | 6'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/spc_step.sv
// per-word evaluation: next pending set, next run state and the result word
// uses spc_pkg and spc_pick
`default_nettype none

module spc_step #(
    parameter int unsigned SIGNAL_MAX = spc_pkg::SigMaxDefault
) (
    input  spc_pkg::t_in_word     i_word,
    input  wire logic [63:0]      i_pending,
    input  spc_pkg::t_run_state   i_run_state,
    input  spc_pkg::t_cfg         i_cfg,
    output logic [63:0]           o_pending_nxt,
    output spc_pkg::t_run_state   o_run_state_nxt,
    output spc_pkg::t_out_word    o_result
);

    localparam logic [63:0] RangeMask = spc_pkg::valid_mask(SIGNAL_MAX);

    logic [63:0] custom_eff;
    logic [63:0] ignore_eff;
    logic [63:0] sig_bit;
    logic [63:0] cand;
    logic        found;
    logic [5:0]  pick_idx;
    logic [63:0] pick_bit;
    logic [2:0]  pick_act;
    logic        sig_ok;
    logic        dead;

    // kill and stop always take the default action; custom wins over ignore
    assign custom_eff = i_cfg.custom & ~spc_pkg::UncatchSet;
    assign ignore_eff = i_cfg.ignore & ~i_cfg.custom & ~spc_pkg::UncatchSet;

    assign sig_bit  = 64'd1 << i_word.signal_number;
    assign sig_ok   = RangeMask[i_word.signal_number];
    assign dead     = (i_run_state == spc_pkg::RUN_DEAD);
    assign cand     = i_pending & ~i_cfg.blocked & RangeMask &
                      (i_word.custom_ok ? '1 : ~custom_eff);
    assign pick_bit = 64'd1 << pick_idx;

    spc_pick u_pick (
        .i_cand  (cand),
        .o_found (found),
        .o_index (pick_idx)
    );

    always_comb begin
        if (custom_eff[pick_idx]) begin
            pick_act = spc_pkg::ActCustom;
        end else if (ignore_eff[pick_idx]) begin
            pick_act = spc_pkg::ActHIgn;
        end else begin
            pick_act = spc_pkg::default_action(pick_idx);
        end
    end

    // next state
    always_comb begin
        o_pending_nxt   = i_pending;
        o_run_state_nxt = i_run_state;
        if (i_word.func == spc_pkg::FuncSend) begin
            if (sig_ok && !dead && !ignore_eff[i_word.signal_number]) begin
                if (i_word.signal_number == spc_pkg::SCont) begin
                    o_pending_nxt = o_pending_nxt & ~spc_pkg::StopSet;
                end
                o_pending_nxt = o_pending_nxt | sig_bit;
                if (i_run_state == spc_pkg::RUN_STOPPED &&
                    (i_word.signal_number == spc_pkg::SCont ||
                     i_word.signal_number == spc_pkg::SKill)) begin
                    o_run_state_nxt = spc_pkg::RUN_READY;
                end
            end
        end else if (!dead && found) begin
            o_pending_nxt = i_pending & ~pick_bit;
            case (pick_act) inside
                spc_pkg::ActTerm, spc_pkg::ActCore: o_run_state_nxt = spc_pkg::RUN_DEAD;
                spc_pkg::ActStop:                   o_run_state_nxt = spc_pkg::RUN_STOPPED;
                spc_pkg::ActCont:                   o_run_state_nxt = spc_pkg::RUN_READY;
                default:                            o_run_state_nxt = i_run_state;
            endcase
        end
    end

    // result word
    always_comb begin
        o_result               = '0;
        o_result.run_state_out = o_run_state_nxt;
        o_result.resumed       = (i_run_state == spc_pkg::RUN_STOPPED) &&
                                 (o_run_state_nxt == spc_pkg::RUN_READY);
        if (i_word.func == spc_pkg::FuncSend) begin
            if (!sig_ok) begin
                o_result.status = spc_pkg::StatInvalid;
            end else if (dead) begin
                o_result.status = spc_pkg::StatNoTask;
            end
        end else if (dead) begin
            o_result.status = spc_pkg::StatNoTask;
        end else if (found) begin
            o_result.picked_signal = pick_idx;
            o_result.action_taken  = pick_act;
        end
    end

endmodule

`default_nettype wire
